FILE: design/srt_pkg.sv
// Shared types, constants and helper functions for the soil radiant temperature unit.
// No dependencies; imported by the top level and the assertion checker.
`default_nettype none

package srt_pkg;

  // pipeline layout
  localparam int Sq1Base    = 11;
  localparam int Sq1Stages  = 8;
  localparam int Sq2Stages  = 4;
  localparam int StepsPerSq = 4;
  localparam int Sq2Base    = Sq1Base + Sq1Stages;
  localparam int OutStage   = Sq2Base + Sq2Stages;
  localparam int NumStages  = OutStage + 1;

  // fixed-point constants
  localparam logic [15:0] KelvinIn  = 16'd17480;
  localparam logic [17:0] KelvinOut = 18'd17482;
  localparam logic [30:0] RecipU    = 31'd1374389535; // ceil(2^37 / 100)
  localparam logic [26:0] RecipB    = 27'd87960931;   // ceil(2^39 / 6250)
  localparam logic [27:0] BentC     = 28'd204390400;
  localparam logic [63:0] Offset273 = 64'd4580179968;
  localparam logic [29:0] FluxGain  = 30'd779650539;
  localparam logic [14:0] ProjGain  = 15'd20185;
  localparam logic [4:0]  TabLast   = 5'd18;
  localparam logic signed [14:0] OutLow  = -15'sd6400;
  localparam logic signed [14:0] OutHigh = 15'sd12800;

  typedef struct packed {
    logic [63:0] n;
    logic [35:0] rem;
    logic [31:0] root;
  } sq1_t;

  typedef struct packed {
    logic [31:0] n;
    logic [19:0] rem;
    logic [15:0] root;
  } sq2_t;

  // cosine at 5 degree steps, Q16
  function automatic logic [16:0] cos_q16(input logic [4:0] idx);
    case (idx)
      5'd0:    return 17'd65536;
      5'd1:    return 17'd65287;
      5'd2:    return 17'd64540;
      5'd3:    return 17'd63303;
      5'd4:    return 17'd61584;
      5'd5:    return 17'd59396;
      5'd6:    return 17'd56756;
      5'd7:    return 17'd53684;
      5'd8:    return 17'd50203;
      5'd9:    return 17'd46341;
      5'd10:   return 17'd42126;
      5'd11:   return 17'd37590;
      5'd12:   return 17'd32768;
      5'd13:   return 17'd27697;
      5'd14:   return 17'd22415;
      5'd15:   return 17'd16962;
      5'd16:   return 17'd11380;
      5'd17:   return 17'd5712;
      default: return 17'd0;
    endcase
  endfunction

  // a few restoring square root steps on the wide radicand
  function automatic sq1_t sqrt1_steps(input sq1_t x);
    sq1_t y;
    logic [35:0] trial;
    y = x;
    for (int i = 0; i < StepsPerSq; i++) begin
      y.root = {y.root[30:0], 1'b0};
      y.rem  = {y.rem[33:0], y.n[63:62]};
      y.n    = {y.n[61:0], 2'b00};
      trial  = {3'b000, y.root, 1'b1};
      if (y.rem >= trial) begin
        y.rem     = y.rem - trial;
        y.root[0] = 1'b1;
      end
    end
    return y;
  endfunction

  // a few restoring square root steps on the narrow radicand
  function automatic sq2_t sqrt2_steps(input sq2_t x);
    sq2_t y;
    logic [19:0] trial;
    y = x;
    for (int i = 0; i < StepsPerSq; i++) begin
      y.root = {y.root[14:0], 1'b0};
      y.rem  = {y.rem[17:0], y.n[31:30]};
      y.n    = {y.n[29:0], 2'b00};
      trial  = {3'b000, y.root, 1'b1};
      if (y.rem >= trial) begin
        y.rem     = y.rem - trial;
        y.root[0] = 1'b1;
      end
    end
    return y;
  endfunction

endpackage

`default_nettype wire

FILE: design/soil_radiant_temperature_unit.sv
// Soil radiant temperature pipeline: Kelvin fourth power, sun projection, flux sum, fourth root.
// Depends on srt_pkg for constants, the cosine table and the square root step functions.

// One transaction enters per cycle while in_stall_o is low; its result reaches the outputs through
// the 24 register stages, the first of which loads at the
// accepting edge: eleven for the soil power, the projection and the flux sum, eight
// for the 64-bit square root and four for the second root, four root bits per stage, plus the
// output register. Every stage carries its own valid bit and moves forward whenever the stage
// after it is empty or moving, so bubbles close up and in_stall_o rises only when all stages
// hold data and the output is stalled. There is no state between transactions.
`default_nettype none

module soil_radiant_temperature_unit import srt_pkg::*; (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire  logic signed [13:0] soil_temp_i,
  input  wire  logic        [12:0] shortwave_down_i,
  input  wire  logic        [12:0] shortwave_up_i,
  input  wire  logic signed [13:0] sun_elevation_i,
  input  wire                      last_i,
  output logic                     out_valid_o,
  input  wire                      out_stall_i,
  output logic signed [14:0]       radiant_temp_o,
  output logic                     saturated_o,
  output logic                     last_out_o
);

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] lst_q;

  // stage enables: move when the next stage is empty or moving
  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // last flag rides along
  always_ff @(posedge clk_i) begin
    if (en[0]) lst_q[0] <= last_i;
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) lst_q[k] <= lst_q[k-1];
    end
  end

  // stage 0: kelvin square, elevation square
  logic signed [15:0] tks;
  logic [14:0] tk;
  logic [29:0] p0_t2_q;
  logic [25:0] p0_esq_q;
  logic [12:0] p0_e_q;
  logic [6:0]  p_neg_q;
  logic [12:0] p_dn_q [8];
  logic [12:0] p_up_q [8];

  assign tks = 16'(soil_temp_i) + $signed(KelvinIn);
  assign tk  = tks[14:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p0_t2_q  <= 30'(tk) * 30'(tk);
      p0_esq_q <= 26'(sun_elevation_i[12:0]) * 26'(sun_elevation_i[12:0]);
      p0_e_q   <= sun_elevation_i[12:0];
    end
  end

  // below-horizon flag and flux words travel to their use
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p_neg_q[0] <= sun_elevation_i[13];
      p_dn_q[0]  <= shortwave_down_i;
      p_up_q[0]  <= shortwave_up_i;
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) p_neg_q[k] <= p_neg_q[k-1];
    end
    for (int k = 1; k < 8; k++) begin
      if (en[k]) begin
        p_dn_q[k] <= p_dn_q[k-1];
        p_up_q[k] <= p_up_q[k-1];
      end
    end
  end

  // stage 1: reciprocal product for t2/100, bent angle numerator
  logic [60:0] p1_pu_q;
  logic [29:0] p1_t2_q;
  logic [40:0] p1_m2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_pu_q <= 61'(p0_t2_q) * 61'(RecipU);
      p1_t2_q <= p0_t2_q;
      p1_m2_q <= 41'(p0_e_q) * 41'(BentC - 28'(p0_esq_q));
    end
  end

  // stage 2: split t2 = 100*u + v, reciprocal product for angle / 204800000
  logic [23:0] u2;
  logic [6:0]  v2;
  logic [25:0] y2;
  logic [23:0] p2_u_q;
  logic [6:0]  p2_v_q;
  logic [29:0] p2_t2_q;
  logic [52:0] p2_py_q;

  assign u2 = p1_pu_q[60:37];
  assign v2 = 7'(p1_t2_q - 30'(u2) * 30'd100);
  assign y2 = p1_m2_q[40:15];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      p2_u_q  <= u2;
      p2_v_q  <= v2;
      p2_t2_q <= p1_t2_q;
      p2_py_q <= 53'(y2) * 53'(RecipB);
    end
  end

  // stage 3: fourth power and the pieces of 3*q/100, bent angle
  logic [59:0] p3_q_q;
  logic [47:0] p3_uu_q;
  logic [30:0] p3_uv_q;
  logic [14:0] p3_vv3_q;
  logic [12:0] p3_b_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      p3_q_q   <= 60'(p2_t2_q) * 60'(p2_t2_q);
      p3_uu_q  <= 48'(p2_u_q) * 48'(p2_u_q);
      p3_uv_q  <= 31'(p2_u_q) * 31'(p2_v_q);
      p3_vv3_q <= 15'(p2_v_q) * 15'(p2_v_q) * 15'd3;
      p3_b_q   <= 13'(p2_py_q >> 39);
    end
  end

  // stage 4: floor(3q/100), table index and fraction
  logic [14:0] vdiv4;
  logic [4:0]  idx4;
  logic [59:0] p4_q_q;
  logic [59:0] p4_sub_q;
  logic [4:0]  p4_idx_q;
  logic [8:0]  p4_frac_q;

  assign vdiv4 = 15'((32'(p3_vv3_q) * 32'd5243) >> 19);
  assign idx4  = 5'((17'(p3_b_q[12:6]) * 17'd205) >> 10);

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      p4_q_q    <= p3_q_q;
      p4_sub_q  <= 60'(p3_uu_q) * 60'd300 + 60'(p3_uv_q) * 60'd6 + 60'(vdiv4);
      p4_idx_q  <= idx4;
      p4_frac_q <= 9'(p3_b_q - 13'(idx4) * 13'd320);
    end
  end

  // stage 5: soil term, table lookup and slope product
  logic [16:0] t_cur5;
  logic [16:0] t_nxt5;
  logic [59:0] p_a_q [5:9];
  logic [16:0] p5_t_q;
  logic [25:0] p5_prod_q;

  always_comb begin
    t_cur5 = cos_q16(p4_idx_q);
    t_nxt5 = cos_q16(p4_idx_q + 5'd1);
    if (p4_idx_q >= TabLast) begin
      t_cur5 = cos_q16(TabLast);
      t_nxt5 = cos_q16(TabLast);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      p_a_q[5]  <= p4_q_q - p4_sub_q;
      p5_t_q    <= t_cur5;
      p5_prod_q <= 26'(t_cur5 - t_nxt5) * 26'(p4_frac_q);
    end
    for (int k = 6; k < 10; k++) begin
      if (en[k]) p_a_q[k] <= p_a_q[k-1];
    end
  end

  // stage 6: interpolated cosine
  logic [19:0] z6;
  logic [16:0] p6_c_q;

  assign z6 = p5_prod_q[25:6];

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      p6_c_q <= p5_t_q - 17'((37'(z6) * 37'd52429) >> 18);
    end
  end

  // stage 7: projection factor, zero below the horizon
  logic [33:0] pjm7;
  logic [14:0] p7_pj_q;

  assign pjm7 = 34'(p6_c_q) * 34'(ProjGain) + 34'd32768;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      p7_pj_q <= p_neg_q[6] ? 15'd0 : pjm7[30:16];
    end
  end

  // stage 8: flux word
  logic [29:0] p8_w_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      p8_w_q <= {1'b0, p_up_q[7], 16'd0} + 30'(p_dn_q[7]) * 30'(p7_pj_q);
    end
  end

  // stage 9: scaled flux
  logic [59:0] p9_wf_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      p9_wf_q <= 60'(p8_w_q) * 60'(FluxGain);
    end
  end

  // stage 10: radiative sum
  logic [63:0] p10_s_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      p10_s_q <= Offset273 + 64'(p_a_q[9]) + 64'(p9_wf_q);
    end
  end

  // first square root, four bits per stage
  sq1_t sq1_q [Sq1Stages];
  sq1_t sq1_in [Sq1Stages];

  always_comb begin
    sq1_in[0] = '{n: p10_s_q, rem: '0, root: '0};
    for (int j = 1; j < Sq1Stages; j++) begin
      sq1_in[j] = sq1_q[j-1];
    end
  end

  for (genvar j = 0; j < Sq1Stages; j++) begin : g_sq1
    always_ff @(posedge clk_i) begin
      if (en[Sq1Base+j]) sq1_q[j] <= sqrt1_steps(sq1_in[j]);
    end
  end

  // second square root, four bits per stage
  sq2_t sq2_q [Sq2Stages];
  sq2_t sq2_in [Sq2Stages];

  always_comb begin
    sq2_in[0] = '{n: sq1_q[Sq1Stages-1].root, rem: '0, root: '0};
    for (int j = 1; j < Sq2Stages; j++) begin
      sq2_in[j] = sq2_q[j-1];
    end
  end

  for (genvar j = 0; j < Sq2Stages; j++) begin : g_sq2
    always_ff @(posedge clk_i) begin
      if (en[Sq2Base+j]) sq2_q[j] <= sqrt2_steps(sq2_in[j]);
    end
  end

  // output register: celsius offset and saturation
  logic signed [17:0] res_o;
  logic signed [14:0] out_temp_q;
  logic               out_sat_q;

  assign res_o = $signed({2'b00, sq2_q[Sq2Stages-1].root}) - $signed(KelvinOut);

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      if (res_o < 18'(OutLow)) begin
        out_temp_q <= OutLow;
        out_sat_q  <= 1'b1;
      end else if (res_o > 18'(OutHigh)) begin
        out_temp_q <= OutHigh;
        out_sat_q  <= 1'b1;
      end else begin
        out_temp_q <= res_o[14:0];
        out_sat_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o    = v_q[OutStage];
  assign radiant_temp_o = out_temp_q;
  assign saturated_o    = out_sat_q;
  assign last_out_o     = lst_q[OutStage];

endmodule

`default_nettype wire

FILE: design/srt_checker.sv
// Port-level assertions for the soil radiant temperature unit, and the bind that attaches them.
// Depends on srt_pkg for the output range.
`default_nettype none

module srt_checker import srt_pkg::*; (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_stall_o,
  input wire  logic signed [13:0] soil_temp_i,
  input wire  logic        [12:0] shortwave_down_i,
  input wire  logic        [12:0] shortwave_up_i,
  input wire  logic signed [13:0] sun_elevation_i,
  input wire                      last_i,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire  logic signed [14:0] radiant_temp_o,
  input wire                      saturated_o,
  input wire                      last_out_o
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result does not change
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(radiant_temp_o) && $stable(saturated_o) && $stable(last_out_o))
    else $error("stalled result changed");

  // an empty output never stalls the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // saturation flag marks a clipped bound
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> radiant_temp_o == OutLow || radiant_temp_o == OutHigh)
    else $error("saturated result not at a bound");

  // result always within range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> radiant_temp_o >= OutLow && radiant_temp_o <= OutHigh)
    else $error("result out of range");

endmodule

bind soil_radiant_temperature_unit srt_checker u_srt_checker (.*);

`default_nettype wire
